// ----- rtl/dual_encoder_speed_error_sampler_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual encoder speed error sampler
// Concurrent assertion shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_ENCODER_SPEED_ERROR_SAMPLER_CORE_ASSERT_SVH
`define DUAL_ENCODER_SPEED_ERROR_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define DESS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define DESS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define DESS_ASSERT_NEXT_ANY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/dess_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler package
// Shared types and constants for the front end, frame queue and back end.
// ----------------------------------------------------------------------------
package dess_pkg;

  // Header byte that opens every frame (-86 as a signed byte).
  localparam logic [7:0] FRAME_HEADER = 8'hAA;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SETPOINT_LEFT    = 3'd0;
  localparam logic [2:0] REG_SETPOINT_RIGHT   = 3'd1;
  localparam logic [2:0] REG_ERROR_MAX        = 3'd2;
  localparam logic [2:0] REG_ERROR_MIN        = 3'd3;
  localparam logic [2:0] REG_TICKS_PER_SAMPLE = 3'd4;

  // Reset values of the registers.
  localparam logic signed [7:0] SETPOINT_RESET  = 8'sd4;
  localparam logic signed [7:0] ERROR_MAX_RESET = 8'sd15;
  localparam logic signed [7:0] ERROR_MIN_RESET = -8'sd15;
  localparam logic [7:0]        TICKS_RESET     = 8'd4;

  // One measured period: the two clamped speed errors.
  typedef struct packed {
    logic [7:0] err_left;
    logic [7:0] err_right;
  } frame_t;

  // Occupancy flags of the frame queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- rtl/dess_front.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler: front end
// Takes input beats, updates the pulse counts and the tick divider, and
// pushes a frame of clamped errors into the queue at the end of each period.
// ----------------------------------------------------------------------------
module dess_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic                   left_phase_a,
  input  logic                   left_phase_b,
  input  logic                   right_phase_a,
  input  logic                   right_phase_b,
  input  logic signed [7:0]      setpoint_left,
  input  logic signed [7:0]      setpoint_right,
  input  logic signed [7:0]      error_max,
  input  logic signed [7:0]      error_min,
  input  logic [7:0]             ticks_per_sample,
  input  dess_pkg::queue_status_t q_status,
  output logic                   push,
  output dess_pkg::frame_t       push_frame
);

  // Setpoint minus count, wrapped to a byte, then raised to the minimum and
  // lowered to the maximum in that order.
  function automatic logic [7:0] clamp_error(input logic [7:0] setpoint,
                                             input logic [7:0] count,
                                             input logic signed [7:0] lo,
                                             input logic signed [7:0] hi);
    logic signed [7:0] e;
    e = $signed(setpoint - count);
    if (e <= lo) begin
      e = lo;
    end
    if (e >= hi) begin
      e = hi;
    end
    return e;
  endfunction

  logic [7:0] left_count;
  logic [7:0] right_count;
  logic [1:0] left_direction;
  logic [1:0] right_direction;
  logic [7:0] tick_divider;

  logic       accept;
  logic [1:0] left_direction_next;
  logic [1:0] right_direction_next;
  logic [7:0] tick_divider_next;
  logic       period_end;

  // The front only waits when the queue has no room for a frame.
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // A high A level loads the step from B; the wheels count in opposite senses.
  assign left_direction_next  = left_phase_a ? (left_phase_b ? 2'b11 : 2'b01) : left_direction;
  assign right_direction_next = right_phase_a ? (right_phase_b ? 2'b01 : 2'b11) : right_direction;

  assign tick_divider_next = tick_divider + 8'd1;
  assign period_end        = (tick_divider_next == ticks_per_sample);

  // Frame push at the end of a period.
  assign push                 = accept && command && period_end;
  assign push_frame.err_left  = clamp_error(setpoint_left, left_count, error_min, error_max);
  assign push_frame.err_right = clamp_error(setpoint_right, right_count, error_min, error_max);

  // Count and divider state.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count      <= '0;
      right_count     <= '0;
      left_direction  <= '0;
      right_direction <= '0;
      tick_divider    <= '0;
    end else if (accept) begin
      if (!command) begin
        left_direction  <= left_direction_next;
        right_direction <= right_direction_next;
        left_count      <= left_count + {{6{left_direction_next[1]}}, left_direction_next};
        right_count     <= right_count + {{6{right_direction_next[1]}}, right_direction_next};
      end else if (period_end) begin
        tick_divider <= '0;
        left_count   <= '0;
        right_count  <= '0;
      end else begin
        tick_divider <= tick_divider_next;
      end
    end
  end

endmodule

// ----- rtl/dess_queue.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler: frame queue
// Small first-in first-out store of finished frames between front and back.
// ----------------------------------------------------------------------------
module dess_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  dess_pkg::frame_t        push_frame,
  input  logic                    pop,
  output dess_pkg::frame_t        head_frame,
  output dess_pkg::queue_status_t status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dess_pkg::frame_t slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign head_frame   = slots[rd_ptr];

  // Pointers and fill level; the depth is a power of two so pointers wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

endmodule

// ----- rtl/dess_back.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler: back end
// Takes frames from the queue and sends each as header, left and right beats.
// ----------------------------------------------------------------------------
module dess_back (
  input  logic                    clk,
  input  logic                    rst,
  input  dess_pkg::queue_status_t q_status,
  input  dess_pkg::frame_t        head_frame,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HEAD  = 4'b0010,
    ST_LEFT  = 4'b0100,
    ST_RIGHT = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  dess_pkg::frame_t frame;
  logic             out_fire;

  assign out_valid = (state != ST_IDLE);
  assign out_fire  = out_valid && out_ready;

  // Load the next frame when idle or right as the last beat leaves.
  assign pop = !q_status.empty && ((state == ST_IDLE) || ((state == ST_RIGHT) && out_fire));

  // Beat sequencing.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (out_fire) begin
          state_next = ST_LEFT;
        end
      end
      ST_LEFT: begin
        if (out_fire) begin
          state_next = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        if (out_fire) begin
          state_next = q_status.empty ? ST_IDLE : ST_HEAD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame held for the three beats.
  always_ff @(posedge clk) begin
    if (pop) begin
      frame <= head_frame;
    end
  end

  // Beat payload.
  always_comb begin
    case (state)
      ST_HEAD:  out_byte = dess_pkg::FRAME_HEADER;
      ST_LEFT:  out_byte = frame.err_left;
      ST_RIGHT: out_byte = frame.err_right;
      default:  out_byte = '0;
    endcase
  end

  assign out_last = (state == ST_RIGHT);

endmodule

// ----- rtl/dual_encoder_speed_error_sampler_core.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler core
// Counts quadrature pulses of two wheels and reports per-period speed errors.
// ----------------------------------------------------------------------------
// Usage: one input beat is taken every clock cycle; edge beats update the two
// pulse counts and tick beats advance the period divider, both in the cycle
// of acceptance. Each completed period yields a frame of three output beats
// (header, left error, right error with tlast), sent by the back end at one
// beat per cycle unless stalled. Up to FRAME_QUEUE_DEPTH finished frames wait
// in the frame queue, and input stalls only when that queue is full, so the
// sustained rate is one beat per cycle while frames come no faster than the
// back end sends them. Registers read back unchanged; they are to be written
// over the APB port only while the block is idle, which it does not enforce.
module dual_encoder_speed_error_sampler_core #(
  parameter int FRAME_QUEUE_DEPTH = 2  // power of two, 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] left_phase_a, [1] left_phase_b,
                                 // [2] right_phase_a, [3] right_phase_b, [7:4] zero
  input  logic [0:0]  s_tuser,   // [0] command: 0 encoder edge, 1 timer tick
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] frame_byte
  output logic        m_tlast,   // frame_last
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [7:0] setpoint_left;
  logic signed [7:0] setpoint_right;
  logic signed [7:0] error_max;
  logic signed [7:0] error_min;
  logic [7:0]        ticks_per_sample;

  logic                    cfg_write;
  logic [2:0]              cfg_index;
  logic                    push;
  logic                    pop;
  dess_pkg::frame_t        push_frame;
  dess_pkg::frame_t        head_frame;
  dess_pkg::queue_status_t q_status;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_left    <= dess_pkg::SETPOINT_RESET;
      setpoint_right   <= dess_pkg::SETPOINT_RESET;
      error_max        <= dess_pkg::ERROR_MAX_RESET;
      error_min        <= dess_pkg::ERROR_MIN_RESET;
      ticks_per_sample <= dess_pkg::TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dess_pkg::REG_SETPOINT_LEFT:    setpoint_left    <= $signed(pwdata[7:0]);
        dess_pkg::REG_SETPOINT_RIGHT:   setpoint_right   <= $signed(pwdata[7:0]);
        dess_pkg::REG_ERROR_MAX:        error_max        <= $signed(pwdata[7:0]);
        dess_pkg::REG_ERROR_MIN:        error_min        <= $signed(pwdata[7:0]);
        dess_pkg::REG_TICKS_PER_SAMPLE: ticks_per_sample <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_index)
      dess_pkg::REG_SETPOINT_LEFT:    prdata = {24'd0, setpoint_left};
      dess_pkg::REG_SETPOINT_RIGHT:   prdata = {24'd0, setpoint_right};
      dess_pkg::REG_ERROR_MAX:        prdata = {24'd0, error_max};
      dess_pkg::REG_ERROR_MIN:        prdata = {24'd0, error_min};
      dess_pkg::REG_TICKS_PER_SAMPLE: prdata = {24'd0, ticks_per_sample};
      default:                        prdata = '0;
    endcase
  end

  dess_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .command          (s_tuser[0]),
    .left_phase_a     (s_tdata[0]),
    .left_phase_b     (s_tdata[1]),
    .right_phase_a    (s_tdata[2]),
    .right_phase_b    (s_tdata[3]),
    .setpoint_left    (setpoint_left),
    .setpoint_right   (setpoint_right),
    .error_max        (error_max),
    .error_min        (error_min),
    .ticks_per_sample (ticks_per_sample),
    .q_status         (q_status),
    .push             (push),
    .push_frame       (push_frame)
  );

  dess_queue #(
    .DEPTH (FRAME_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head_frame (head_frame),
    .status     (q_status)
  );

  dess_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head_frame (head_frame),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ----- rtl/dess_checker.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler: port checker
// Watches the top-level ports for frame structure and stream behavior.
// ----------------------------------------------------------------------------
`include "dual_encoder_speed_error_sampler_core_assert.svh"

module dess_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled output beat holds its payload.
  `DESS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")

  // Right after the last beat of a frame, the output is either idle or shows a new header.
  `DESS_ASSERT_NEXT(a_header_follows, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tdata == dess_pkg::FRAME_HEADER && !m_tlast), "frame did not open with header")

  // Inside a frame the beats follow without gaps.
  `DESS_ASSERT_NEXT(a_frame_gapless, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a frame")

  // Right after reset the input side is open.
  `DESS_ASSERT_NEXT_ANY(a_ready_after_reset, rst, s_tready, "input not ready after reset")

endmodule

bind dual_encoder_speed_error_sampler_core dess_checker u_dess_checker (.*);

// ----- dv/dess_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler test package
// Input beat command codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package dess_tb_pkg;

  // Meaning of the tuser bit on the input stream.
  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_TICK = 1'b1
  } command_e;

endpackage

// ----- dv/dess_speed_error_checker.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error checker
// Watches the input, output and register channels of the sampler, keeps its
// own copy of the pulse counts, directions, divider and registers, predicts
// every frame byte and compares the output stream against it in order.
// ----------------------------------------------------------------------------
module dess_speed_error_checker
  import dess_pkg::*;
  import dess_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] left_phase_a, [1] left_phase_b,
                                 // [2] right_phase_a, [3] right_phase_b
  input  logic [0:0]  s_tuser,   // [0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] frame_byte
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned pending_beats,
  output int unsigned frames_checked,
  output int unsigned error_count
);

  // One predicted output beat.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_beat_t;

  frame_beat_t frame_beats_due[$];
  frame_beat_t oldest;

  // Register copies.
  logic signed [7:0] sp_left, sp_right, err_hi, err_lo;
  logic [7:0]        period;

  // Measurement state.
  logic [7:0] cnt_left, cnt_right, divider;
  logic [1:0] dir_left, dir_right;

  initial begin
    error_count    = 0;
    frames_checked = 0;
    pending_beats  = 0;
  end

  task automatic report(input string what);
    error_count++;
    $display("%0t ERROR %s", $time, what);
  endtask

  // Setpoint minus count as a wrapped signed byte, raised to the lower bound
  // first and then lowered to the upper bound.
  function automatic logic [7:0] clamped_error(input logic [7:0] setp,
                                               input logic [7:0] cnt);
    logic signed [7:0] e;
    e = setp - cnt;
    if (e <= err_lo) e = err_lo;
    if (e >= err_hi) e = err_hi;
    return e;
  endfunction

  // An edge beat: A high reloads the direction from B, then the direction
  // (a 2-bit signed step) is added to the count.
  task automatic count_edges(input logic [3:0] ph);
    if (ph[0]) dir_left  = ph[1] ? 2'b11 : 2'b01;
    if (ph[2]) dir_right = ph[3] ? 2'b01 : 2'b11;
    cnt_left  = cnt_left  + {{6{dir_left[1]}}, dir_left};
    cnt_right = cnt_right + {{6{dir_right[1]}}, dir_right};
  endtask

  // A tick beat: the divider advances and, on a match, closes the period.
  task automatic count_tick();
    divider = divider + 8'd1;
    if (divider == period) begin
      divider = 8'd0;
      frame_beats_due.push_back({FRAME_HEADER, 1'b0});
      frame_beats_due.push_back({clamped_error(sp_left, cnt_left), 1'b0});
      frame_beats_due.push_back({clamped_error(sp_right, cnt_right), 1'b1});
      cnt_left  = 8'd0;
      cnt_right = 8'd0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sp_left   = SETPOINT_RESET;
      sp_right  = SETPOINT_RESET;
      err_hi    = ERROR_MAX_RESET;
      err_lo    = ERROR_MIN_RESET;
      period    = TICKS_RESET;
      cnt_left  = 8'd0;
      cnt_right = 8'd0;
      dir_left  = 2'b00;
      dir_right = 2'b00;
      divider   = 8'd0;
      frame_beats_due.delete();
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SETPOINT_LEFT:    sp_left  = pwdata[7:0];
          REG_SETPOINT_RIGHT:   sp_right = pwdata[7:0];
          REG_ERROR_MAX:        err_hi   = pwdata[7:0];
          REG_ERROR_MIN:        err_lo   = pwdata[7:0];
          REG_TICKS_PER_SAMPLE: period   = pwdata[7:0];
          default: ;
        endcase
      end

      // Input beats.
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == CMD_TICK) count_tick();
        else count_edges(s_tdata[3:0]);
      end

      // Output beats against the oldest prediction.
      if (m_tvalid && m_tready) begin
        if (frame_beats_due.size() == 0) begin
          report($sformatf("unexpected output beat data %02h last %b", m_tdata, m_tlast));
        end else begin
          oldest = frame_beats_due.pop_front();
          if (m_tdata !== oldest.value)
            report($sformatf("frame byte %02h, expected %02h", m_tdata, oldest.value));
          if (m_tlast !== oldest.last)
            report($sformatf("tlast %b, expected %b", m_tlast, oldest.last));
          if (oldest.last) frames_checked++;
        end
      end
    end
    pending_beats <= frame_beats_due.size();
  end

endmodule

// ----- dv/tb_dual_encoder_speed_error_sampler_core.sv -----
// ----------------------------------------------------------------------------
// Dual encoder speed error sampler testbench
// Drives edge and tick beats and register writes into the sampler, with
// random gaps and output stalls, and lets the checker compare every frame.
// ----------------------------------------------------------------------------
module tb_dual_encoder_speed_error_sampler_core;
  import dess_pkg::*;
  import dess_tb_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid, s_tready;
  logic [7:0]  s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  int unsigned pending_beats, frames_checked, error_count;
  int unsigned items_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned stall_count = 0;
  bit          gaps_on = 1'b1;
  bit          s_taken = 1'b0;
  bit          apb_taken = 1'b0;

  always #5 clk = ~clk;

  dual_encoder_speed_error_sampler_core dut (.*);

  dess_speed_error_checker err_check (.*);

  // Handshake flags for the stimulus, read at the following falling edge.
  always @(posedge clk) begin
    s_taken   <= s_tvalid && s_tready;
    apb_taken <= psel && penable && pwrite && pready;
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
      stall_count <= 0;
    else if (stall_count == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else
      stall_count <= stall_count + 1;
  end

  // Output side: random stall bursts while gaps are enabled.
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else begin
        m_tready = 1'b1;
        if (gaps_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 10);
      end
    end
  end

  // One input beat, with an occasional gap in front of it.
  task automatic send_item(input command_e cmd, input logic [3:0] phases);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tuser  = cmd;
    s_tdata  = {4'b0000, phases};
    s_tvalid = 1'b1;
    do @(negedge clk); while (!s_taken);
    items_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  task automatic run_random(input int n, input int tick_pct);
    command_e cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_EDGE;
      send_item(cmd, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [7:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (!apb_taken);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Registers change only once every predicted frame has gone out.
  task automatic program_regs(input logic [7:0] sl, input logic [7:0] sr,
                              input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] per);
    s_tvalid = 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_write(REG_SETPOINT_LEFT, sl);
    apb_write(REG_SETPOINT_RIGHT, sr);
    apb_write(REG_ERROR_MAX, hi);
    apb_write(REG_ERROR_MIN, lo);
    apb_write(REG_TICKS_PER_SAMPLE, per);
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = CMD_EDGE;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 5'd0;
    pwdata   = 32'h0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Reset settings. With A low on both wheels nothing counts yet, since the
    // direction starts at zero; then every phase combination as an edge, and
    // four ticks with phase bits that must be ignored to close a period.
    send_item(CMD_EDGE, 4'b1010);
    for (int p = 0; p < 16; p++) send_item(CMD_EDGE, p[3:0]);
    send_item(CMD_TICK, 4'hF);
    send_item(CMD_TICK, 4'h0);
    send_item(CMD_TICK, 4'h5);
    send_item(CMD_TICK, 4'hA);

    // Setpoint extremes with open clamps, so the difference wraps visibly.
    program_regs(8'sd127, -8'sd128, 8'sd127, -8'sd128, 8'd1);
    run_random(16, 30);

    // Crossed clamps: the lower bound sits above the upper one.
    program_regs(8'sd10, -8'sd10, -8'sd20, 8'sd20, 8'd2);
    run_random(16, 25);

    // Mirrored setpoint extremes, narrow clamps, long edge runs.
    program_regs(-8'sd128, 8'sd127, 8'sd5, -8'sd5, 8'd3);
    run_random(12, 20);

    // Period lowered below the running divider, to zero: the divider has to
    // wrap through 255 before the next frame. The divider is at most eight
    // here, so 250 ticks always reach the wrap.
    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
    repeat (6) send_item(CMD_TICK, 4'($urandom_range(0, 15)));
    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
    for (int i = 0; i < 264; i++) begin
      if (i % 20 == 0)
        send_item(CMD_EDGE, 4'($urandom_range(0, 15)));
      else
        send_item(CMD_TICK, 4'($urandom_range(0, 15)));
    end

    // Back-to-back traffic with random settings and short periods.
    gaps_on = 1'b0;
    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd3);
    run_random(24, 70);

    s_tvalid = 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d input beats (%0d ticks) across reset, extreme and random settings.",
             items_sent, ticks_sent);
    $display("Checked %0d frames, covering crossed clamps and a zero period with wrap.",
             frames_checked);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
